/* sv/cfr_pkg.sv */
// shared types and constants for the command frame receiver
`timescale 1ns / 1ps

package cfr_pkg;

  // frame head bytes
  localparam logic [7:0] HEAD1 = 8'h10;
  localparam logic [7:0] HEAD2 = 8'h01;

  // opcodes
  localparam logic [7:0] OP_BELL = 8'h01;
  localparam logic [7:0] OP_LED  = 8'h02;
  localparam logic [7:0] OP_REQ  = 8'h03;

  // first payload byte values that switch a flag on
  localparam logic [7:0] BELL_ON_CODE = 8'h01;
  localparam logic [7:0] LED_ON_CODE  = 8'h03;

  // result status codes
  typedef enum logic [2:0] {
    ST_BUSY      = 3'd0,
    ST_OK        = 3'd1,
    ST_BAD_HEAD1 = 3'd2,
    ST_BAD_HEAD2 = 3'd3,
    ST_BAD_SUM   = 3'd4,
    ST_TOO_LONG  = 3'd5
  } status_t;

  // one result item, last field in the lowest bits when packed to tdata
  typedef struct packed {
    logic    data_request;
    logic    bell_on;
    logic    led_on;
    status_t status;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

/* sv/command_frame_receiver_core.sv */
// command frame receiver top level: byte stream in, one status transaction out per byte
// an accepted byte's result is registered in the result register, or in the skid entry
//   while that one waits; throughput: one byte per cycle while the skid entry is empty;
//   the parser updates counter, checksum and flags in the same cycle the byte is accepted
// a result register plus one skid entry lets a byte be accepted while a result waits
// reset: synchronous active-low rst_n clears the parser state, both flags and the output valid flags
`timescale 1ns / 1ps

module command_frame_receiver_core #(
  parameter int MAX_PAYLOAD = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  // byte input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  // result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [2:0] status, [3] led_on, [4] bell_on, [5] data_request
);
  import cfr_pkg::*;

  logic    in_fire;
  result_t parse_result;
  result_t out_result;

  // a byte transaction completes when both sides agree
  assign in_fire = in_tvalid & in_tready;

  // parser: all per-byte work happens between the state registers
  cfr_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_fire(in_fire),
    .rx_byte  (in_tdata),
    .result   (parse_result)
  );

  // output stage decouples the sink's backpressure from byte intake
  cfr_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_data (parse_result),
    .push_ready(in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_result)
  );

  // pack result fields, zero fill to a whole byte
  assign out_tdata = {(8 - RESULT_W)'(0), out_result};

endmodule

/* sv/cfr_parser.sv */
// frame parser: position counter, running checksum and control flags
`timescale 1ns / 1ps

module cfr_parser #(
  parameter int MAX_PAYLOAD = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            byte_fire,
  input  logic [7:0]      rx_byte,
  output cfr_pkg::result_t result
);
  import cfr_pkg::*;

  localparam int CNT_W = $clog2(MAX_PAYLOAD + 5);
  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

  localparam logic [CNT_W-1:0] POS_HEAD1   = CNT_W'(0);
  localparam logic [CNT_W-1:0] POS_HEAD2   = CNT_W'(1);
  localparam logic [CNT_W-1:0] POS_OPCODE  = CNT_W'(2);
  localparam logic [CNT_W-1:0] POS_LENGTH  = CNT_W'(3);
  localparam logic [CNT_W-1:0] POS_PAYLOAD = CNT_W'(4);
  localparam logic [7:0]       MAX_LEN     = 8'(MAX_PAYLOAD);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       opcode_r, opcode_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [7:0]       first_r, first_nxt;
  logic             led_r, led_nxt;
  logic             bell_r, bell_nxt;
  status_t          status;
  logic             req;
  logic [7:0]       sum_add;
  logic [CNT_W-1:0] last_payload_end;

  assign sum_add          = sum_r + rx_byte;
  assign last_payload_end = POS_PAYLOAD + CNT_W'(len_r);

  always_comb begin
    count_nxt  = count_r;
    sum_nxt    = sum_r;
    opcode_nxt = opcode_r;
    len_nxt    = len_r;
    first_nxt  = first_r;
    led_nxt    = led_r;
    bell_nxt   = bell_r;
    status     = ST_BUSY;
    req        = 1'b0;
    case (count_r)
      POS_HEAD1: begin
        if (rx_byte != HEAD1) begin
          status = ST_BAD_HEAD1;
        end else begin
          sum_nxt   = rx_byte;
          count_nxt = POS_HEAD2;
        end
      end
      POS_HEAD2: begin
        if (rx_byte != HEAD2) begin
          status    = ST_BAD_HEAD2;
          count_nxt = POS_HEAD1;
          sum_nxt   = 8'd0;
        end else begin
          sum_nxt   = sum_add;
          count_nxt = POS_OPCODE;
        end
      end
      POS_OPCODE: begin
        opcode_nxt = rx_byte;
        sum_nxt    = sum_add;
        count_nxt  = POS_LENGTH;
      end
      POS_LENGTH: begin
        if (rx_byte > MAX_LEN) begin
          status    = ST_TOO_LONG;
          count_nxt = POS_HEAD1;
          sum_nxt   = 8'd0;
        end else begin
          len_nxt   = LEN_W'(rx_byte);
          sum_nxt   = sum_add;
          count_nxt = POS_PAYLOAD;
        end
      end
      default: begin
        // zero length: the checksum byte doubles as the first payload byte
        if (count_r == POS_PAYLOAD) begin
          first_nxt = rx_byte;
        end
        if (count_r < last_payload_end) begin
          sum_nxt   = sum_add;
          count_nxt = count_r + CNT_W'(1);
        end else begin
          if (rx_byte != sum_r) begin
            status = ST_BAD_SUM;
          end else begin
            status = ST_OK;
            if (opcode_r == OP_BELL) begin
              bell_nxt = (first_nxt == BELL_ON_CODE);
            end else if (opcode_r == OP_LED) begin
              led_nxt = (first_nxt == LED_ON_CODE);
            end else if (opcode_r == OP_REQ) begin
              req = 1'b1;
            end
          end
          count_nxt = POS_HEAD1;
          sum_nxt   = 8'd0;
        end
      end
    endcase
  end

  assign result.status       = status;
  assign result.led_on       = led_nxt;
  assign result.bell_on      = bell_nxt;
  assign result.data_request = req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      sum_r    <= '0;
      opcode_r <= '0;
      len_r    <= '0;
      first_r  <= '0;
      led_r    <= 1'b0;
      bell_r   <= 1'b0;
    end else if (byte_fire) begin
      count_r  <= count_nxt;
      sum_r    <= sum_nxt;
      opcode_r <= opcode_nxt;
      len_r    <= len_nxt;
      first_r  <= first_nxt;
      led_r    <= led_nxt;
      bell_r   <= bell_nxt;
    end
  end

endmodule

/* sv/cfr_out_skid.sv */
// result register with one skid entry
`timescale 1ns / 1ps

module cfr_out_skid (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cfr_pkg::result_t push_data,
  output logic             push_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output cfr_pkg::result_t out_data
);
  import cfr_pkg::*;

  logic    main_valid_r;
  logic    skid_valid_r;
  result_t main_data_r;
  result_t skid_data_r;
  logic    taken;

  assign taken      = main_valid_r & out_ready;
  assign push_ready = ~skid_valid_r;
  assign out_valid  = main_valid_r;
  assign out_data   = main_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (taken) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (main_valid_r && !taken) begin
        skid_valid_r <= 1'b1;
      end else begin
        main_valid_r <= 1'b1;
      end
    end else if (taken) begin
      main_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (taken) begin
        main_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (main_valid_r && !taken) begin
        skid_data_r <= push_data;
      end else begin
        main_data_r <= push_data;
      end
    end
  end

endmodule

/* dv/command_frame_receiver_core_tb.sv */
// self-checking testbench for the command frame receiver: frame parsing, flags and backpressure
`timescale 1ns / 1ps

module command_frame_receiver_core_tb;
  import cfr_pkg::*;

  localparam int FRAME_MAX      = 16;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES   = 1650;
  localparam int TAIL_BYTES     = 150;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] rx_byte
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [2:0] status, [3] led_on, [4] bell_on, [5] data_request

  command_frame_receiver_core #(.MAX_PAYLOAD(FRAME_MAX)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  // parser state mirrored for prediction
  int         parse_pos   = 0;
  logic [7:0] parse_sum   = '0;
  logic [7:0] parse_op    = '0;
  logic [7:0] parse_len   = '0;
  logic [7:0] parse_first = '0;
  logic       led_state   = 1'b0;
  logic       bell_state  = 1'b0;

  result_t    status_queue[$];
  result_t    exp_r;
  result_t    got_r;
  int         status_seen[6];
  int         req_seen    = 0;
  int         bytes_sent  = 0;
  int         errors      = 0;
  int         idle_cycles = 0;
  bit         gaps_on     = 1'b1;
  bit         hold_off_req = 1'b0;

  function automatic result_t parse_rx_byte(input logic [7:0] b);
    result_t r;
    r.status       = ST_BUSY;
    r.data_request = 1'b0;
    if (parse_pos == 0) begin
      if (b != HEAD1) begin
        r.status = ST_BAD_HEAD1;
      end else begin
        parse_sum = b;
        parse_pos = 1;
      end
    end else if (parse_pos == 1) begin
      if (b != HEAD2) begin
        r.status  = ST_BAD_HEAD2;
        parse_pos = 0;
        parse_sum = '0;
      end else begin
        parse_sum = parse_sum + b;
        parse_pos = 2;
      end
    end else if (parse_pos == 2) begin
      parse_op  = b;
      parse_sum = parse_sum + b;
      parse_pos = 3;
    end else if (parse_pos == 3) begin
      if (int'(b) > FRAME_MAX) begin
        r.status  = ST_TOO_LONG;
        parse_pos = 0;
        parse_sum = '0;
      end else begin
        parse_len = b;
        parse_sum = parse_sum + b;
        parse_pos = 4;
      end
    end else begin
      // with zero length the checksum byte doubles as the first payload byte
      if (parse_pos == 4) parse_first = b;
      if (parse_pos < 4 + int'(parse_len)) begin
        parse_sum = parse_sum + b;
        parse_pos = parse_pos + 1;
      end else begin
        if (b != parse_sum) begin
          r.status = ST_BAD_SUM;
        end else begin
          r.status = ST_OK;
          if (parse_op == OP_BELL) bell_state = (parse_first == BELL_ON_CODE);
          else if (parse_op == OP_LED) led_state = (parse_first == LED_ON_CODE);
          else if (parse_op == OP_REQ) r.data_request = 1'b1;
        end
        parse_pos = 0;
        parse_sum = '0;
      end
    end
    r.led_on  = led_state;
    r.bell_on = bell_state;
    status_seen[r.status]++;
    if (r.data_request) req_seen++;
    return r;
  endfunction

  // result checker and predictor feed, both on the sampled handshakes
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_r = result_t'(out_tdata[RESULT_W-1:0]);
        if (status_queue.size() == 0) begin
          $display("%0t: result 0x%02h with no transaction pending", $time, out_tdata);
          errors++;
        end else begin
          exp_r = status_queue.pop_front();
          if (got_r.status !== exp_r.status) begin
            $display("%0t: status expected %0d, actual %0d", $time, exp_r.status, got_r.status);
            errors++;
          end
          if (got_r.led_on !== exp_r.led_on) begin
            $display("%0t: led_on expected %0b, actual %0b", $time, exp_r.led_on, got_r.led_on);
            errors++;
          end
          if (got_r.bell_on !== exp_r.bell_on) begin
            $display("%0t: bell_on expected %0b, actual %0b", $time, exp_r.bell_on,
                     got_r.bell_on);
            errors++;
          end
          if (got_r.data_request !== exp_r.data_request) begin
            $display("%0t: data_request expected %0b, actual %0b", $time,
                     exp_r.data_request, got_r.data_request);
            errors++;
          end
          if (out_tdata[7:RESULT_W] !== '0) begin
            $display("%0t: tdata padding expected 0, actual %b", $time,
                     out_tdata[7:RESULT_W]);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready) status_queue.push_back(parse_rx_byte(in_tdata));
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // result side ready: random stalls, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // whole frame; a nonzero sum_flip corrupts the checksum byte
  task automatic send_frame(input logic [7:0] op, input int len, input logic [7:0] first,
                            input logic [7:0] sum_flip);
    logic [7:0] chk;
    logic [7:0] pb;
    chk = HEAD1 + HEAD2 + op + len[7:0];
    send_byte(HEAD1);
    send_byte(HEAD2);
    send_byte(op);
    send_byte(len[7:0]);
    for (int i = 0; i < len; i++) begin
      pb = (i == 0) ? first : 8'($urandom_range(0, 255));
      chk = chk + pb;
      send_byte(pb);
    end
    send_byte(chk ^ sum_flip);
  endtask

  task automatic test_directed_frames();
    send_byte(8'hFF);                       // bad first head, all ones
    send_byte(8'h00);                       // bad first head, all zeros
    send_byte(HEAD1);
    send_byte(8'h00);                       // bad second head
    send_frame(OP_BELL, 1, BELL_ON_CODE, 8'h00);
    send_frame(OP_LED, 1, LED_ON_CODE, 8'h00);
    send_frame(OP_REQ, 0, 8'h00, 8'h00);    // zero length request
    send_byte(HEAD1);
    send_byte(HEAD2);
    send_byte(OP_LED);
    send_byte(8'hFF);                       // length far above the bound
    send_frame(8'hFF, 0, 8'h00, 8'h5A);     // bad checksum, unknown opcode
  endtask

  task automatic test_output_hold_off();
    hold_off_req = 1'b1;
    for (int i = 0; i < 8; i++)
      send_frame(OP_REQ, 2, 8'($urandom_range(0, 255)), 8'h00);
  endtask

  task automatic test_random_traffic(input int n_bytes);
    int         stop_at;
    int         kind;
    int         len;
    logic [7:0] op;
    logic [7:0] first;
    logic [7:0] b;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      kind = $urandom_range(0, 19);
      case ($urandom_range(0, 3))
        0:       op = OP_BELL;
        1:       op = OP_LED;
        2:       op = OP_REQ;
        default: op = 8'($urandom_range(0, 255));
      endcase
      if (kind <= 13) begin
        len = $urandom_range(0, 19);
        if (len == 0)      len = FRAME_MAX;
        else if (len <= 2) len = $urandom_range(0, FRAME_MAX);
        else if (len <= 5) len = 0;
        else               len = $urandom_range(1, 4);
        if ($urandom_range(0, 1)) first = (op == OP_LED) ? LED_ON_CODE : BELL_ON_CODE;
        else                      first = 8'($urandom_range(0, 255));
        send_frame(op, len, first,
                   ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
      end else if (kind <= 15) begin
        send_byte(8'($urandom_range(0, 255)));  // line noise
      end else if (kind == 16) begin
        b = 8'($urandom_range(0, 255));
        if (b == HEAD2) b = b ^ 8'h80;
        send_byte(HEAD1);
        send_byte(b);
      end else if (kind == 17) begin
        send_byte(HEAD1);
        send_byte(HEAD2);
        send_byte(op);
        send_byte(8'($urandom_range(FRAME_MAX + 1, 255)));
      end else begin
        // frame cut off after the opcode, then the next byte sent lands in its length slot
        send_byte(HEAD1);
        send_byte(HEAD2);
        send_byte(op);
      end
    end
  endtask

  task automatic test_streaming_no_gaps();
    gaps_on = 1'b0;
    test_random_traffic(TAIL_BYTES);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_frames();
    test_output_hold_off();
    test_random_traffic(RANDOM_BYTES);
    test_streaming_no_gaps();
    in_tvalid <= 1'b0;

    while (status_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (status_queue.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, status_queue.size());
      errors++;
    end

    $display("sent %0d bytes: %0d frames accepted (%0d data requests), %0d in progress",
             bytes_sent, status_seen[ST_OK], req_seen, status_seen[ST_BUSY]);
    $display("drops: %0d bad head1, %0d bad head2, %0d bad checksum, %0d too long",
             status_seen[ST_BAD_HEAD1], status_seen[ST_BAD_HEAD2],
             status_seen[ST_BAD_SUM], status_seen[ST_TOO_LONG]);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* command_frame_receiver_core.f */
sv/cfr_pkg.sv
sv/cfr_parser.sv
sv/cfr_out_skid.sv
sv/command_frame_receiver_core.sv
dv/command_frame_receiver_core_tb.sv
